/* src/qn_pkg.sv */
// ----------------------------------------------------------------------------
// qn_pkg: shared types and constants for the quaternion normaliser
// Holds the transaction payload structs and the word widths used by the
// front end and the bit cells.
// ----------------------------------------------------------------------------
package qn_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int OUT_WIDTH       = 16;
  // Magnitude of a result is 0 to 2^14, so 15 bits.
  localparam int Q_WIDTH         = 15;
  // Sum of four squares of full-scale components.
  localparam int SUM_WIDTH       = 2 * COMPONENT_WIDTH + 1;
  // Working width for the scaled squares and the running products.
  localparam int WIDE_WIDTH      = 2 * COMPONENT_WIDTH + 34;
  localparam int TARGET_SHIFT    = 30;
  localparam int LANES           = 4;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] in_comp0;
    logic signed [COMPONENT_WIDTH-1:0] in_comp1;
    logic signed [COMPONENT_WIDTH-1:0] in_comp2;
    logic signed [COMPONENT_WIDTH-1:0] in_comp3;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] out_comp0;
    logic signed [OUT_WIDTH-1:0] out_comp1;
    logic signed [OUT_WIDTH-1:0] out_comp2;
    logic signed [OUT_WIDTH-1:0] out_comp3;
    logic                        zero_magnitude;
  } out_item_t;

  // One component in flight: p = x^2 * S, a = x * S with x = 2q - 1, and
  // the target t = 2^30 * c^2.
  typedef struct packed {
    logic signed [WIDE_WIDTH-1:0] p;
    logic signed [WIDE_WIDTH-1:0] a;
    logic signed [WIDE_WIDTH-1:0] t;
    logic [Q_WIDTH-1:0]           q;
    logic                         neg;
  } lane_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0]   s;
    logic                   zero;
    lane_t [LANES-1:0]      lane;
  } work_t;

endpackage

/* src/qn_front.sv */
// ----------------------------------------------------------------------------
// qn_front: magnitudes, squares and sum of squares
// Three registered stages that turn a quaternion into the starting state
// of the bit cells.
// ----------------------------------------------------------------------------
module qn_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  qn_pkg::in_item_t in_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output qn_pkg::work_t    dn_work
);
  import qn_pkg::*;

  logic [COMPONENT_WIDTH-1:0]   mag [LANES];
  logic [LANES-1:0]             neg_a;
  logic                         valid_a;
  logic [2*COMPONENT_WIDTH-1:0] sq [LANES];
  logic [LANES-1:0]             neg_b;
  logic                         valid_b;
  logic                         valid_c;
  work_t                        work;
  work_t                        work_next;
  logic                         ready_a;
  logic                         ready_b;
  logic                         ready_c;
  logic signed [COMPONENT_WIDTH-1:0] comp [LANES];

  assign comp[0] = in_item.in_comp0;
  assign comp[1] = in_item.in_comp1;
  assign comp[2] = in_item.in_comp2;
  assign comp[3] = in_item.in_comp3;

  assign ready_c  = !valid_c || dn_ready;
  assign ready_b  = !valid_b || ready_c;
  assign ready_a  = !valid_a || ready_b;
  assign in_stall = !ready_a;
  assign dn_valid = valid_c;
  assign dn_work  = work;

  always_comb begin
    logic [SUM_WIDTH-1:0] s;
    s = '0;
    for (int i = 0; i < LANES; i++) begin
      s = s + SUM_WIDTH'(sq[i]);
    end
    work_next.s    = s;
    work_next.zero = (s == '0);
    for (int i = 0; i < LANES; i++) begin
      work_next.lane[i].t   = $signed(WIDE_WIDTH'(sq[i])) <<< TARGET_SHIFT;
      // q = 0 gives x = -1: x^2 * S = S and x * S = -S.
      work_next.lane[i].p   = $signed(WIDE_WIDTH'(s));
      work_next.lane[i].a   = -$signed(WIDE_WIDTH'(s));
      work_next.lane[i].q   = '0;
      work_next.lane[i].neg = neg_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a <= in_valid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
      if (ready_c) begin
        valid_c <= valid_b;
      end
    end
    if (ready_a) begin
      for (int i = 0; i < LANES; i++) begin
        neg_a[i] <= comp[i][COMPONENT_WIDTH-1];
        mag[i]   <= comp[i][COMPONENT_WIDTH-1] ? COMPONENT_WIDTH'(-comp[i])
                                                : COMPONENT_WIDTH'(comp[i]);
      end
    end
    if (ready_b) begin
      neg_b <= neg_a;
      for (int i = 0; i < LANES; i++) begin
        sq[i] <= mag[i] * mag[i];
      end
    end
    if (ready_c) begin
      work <= work_next;
    end
  end

endmodule

/* src/qn_cell.sv */
// ----------------------------------------------------------------------------
// qn_cell: one result bit of the rounded quotient search
// Tries setting bit BIT of every component's magnitude and keeps it when
// (2q-1)^2 * S stays within 2^30 * c^2, updating the products by shifts.
// ----------------------------------------------------------------------------
module qn_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  qn_pkg::work_t up_work,
  output logic          dn_valid,
  input  logic          dn_ready,
  output qn_pkg::work_t dn_work
);
  import qn_pkg::*;

  logic                         valid;
  work_t                        work;
  work_t                        work_next;
  logic signed [WIDE_WIDTH-1:0] s_wide;

  assign s_wide   = $signed({{(WIDE_WIDTH-SUM_WIDTH){1'b0}}, up_work.s});
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_work  = work;

  // Raising q by 2^BIT raises x by d = 2^(BIT+1):
  // (x+d)^2 S = x^2 S + 2d xS + d^2 S.
  always_comb begin
    logic signed [WIDE_WIDTH-1:0] cand;
    work_next = up_work;
    for (int i = 0; i < LANES; i++) begin
      cand = up_work.lane[i].p + (up_work.lane[i].a <<< (BIT + 2))
           + (s_wide <<< (2 * BIT + 2));
      if (cand <= up_work.lane[i].t) begin
        work_next.lane[i].p      = cand;
        work_next.lane[i].a      = up_work.lane[i].a + (s_wide <<< (BIT + 1));
        work_next.lane[i].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready) begin
      work <= work_next;
    end
  end

endmodule

/* src/quaternion_normalizer.sv */
// ----------------------------------------------------------------------------
// quaternion_normalizer: scales a Q4.12 quaternion to unit length in Q1.14
// Front end plus a chain of fifteen bit cells.
// ----------------------------------------------------------------------------
// A transaction can be taken every clock cycle while in_stall is low. Each one
// passes through eighteen register stages: three for magnitude, squaring and
// summing, then one per result bit in a chain of fifteen cells, each deciding
// one bit of all four rounded quotients with shift-and-add updates. Each stage
// moves on by itself, so bubbles close up under an output stall. An all-zero
// quaternion returns zero components with zero_magnitude set.
module quaternion_normalizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  qn_pkg::in_item_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output qn_pkg::out_item_t out_item
);
  import qn_pkg::*;

  logic  chain_valid [Q_WIDTH+1];
  logic  chain_ready [Q_WIDTH+1];
  work_t chain_work  [Q_WIDTH+1];
  logic signed [OUT_WIDTH-1:0] comp [LANES];

  qn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_work  (chain_work[0])
  );

  for (genvar k = 0; k < Q_WIDTH; k++) begin : g_cell
    qn_cell #(.BIT(Q_WIDTH - 1 - k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_work  (chain_work[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_work  (chain_work[k+1])
    );
  end

  assign chain_ready[Q_WIDTH] = !out_stall;
  assign out_valid            = chain_valid[Q_WIDTH];

  always_comb begin
    logic signed [OUT_WIDTH-1:0] mag;
    for (int i = 0; i < LANES; i++) begin
      mag = $signed(OUT_WIDTH'(chain_work[Q_WIDTH].lane[i].q));
      if (chain_work[Q_WIDTH].zero) begin
        comp[i] = '0;
      end else if (chain_work[Q_WIDTH].lane[i].neg) begin
        comp[i] = -mag;
      end else begin
        comp[i] = mag;
      end
    end
  end

  assign out_item.out_comp0      = comp[0];
  assign out_item.out_comp1      = comp[1];
  assign out_item.out_comp2      = comp[2];
  assign out_item.out_comp3      = comp[3];
  assign out_item.zero_magnitude = chain_work[Q_WIDTH].zero;

endmodule

/* src/qn_checker.sv */
// ----------------------------------------------------------------------------
// qn_checker: port-level checks for the quaternion normaliser
// Watches the result channel and reset behaviour from the top-level ports.
// ----------------------------------------------------------------------------
module qn_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input qn_pkg::out_item_t out_item
);
  import qn_pkg::*;

  // Nothing is in flight straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid in the cycle after reset");

  // A zero-magnitude transaction carries zero components.
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.zero_magnitude) |->
      (out_item.out_comp0 == '0 && out_item.out_comp1 == '0 &&
       out_item.out_comp2 == '0 && out_item.out_comp3 == '0))
    else $error("zero magnitude with non-zero components");

  // Every component of a unit quaternion lies within plus or minus one.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_item.out_comp0 >= -16384 && out_item.out_comp0 <= 16384 &&
       out_item.out_comp1 >= -16384 && out_item.out_comp1 <= 16384 &&
       out_item.out_comp2 >= -16384 && out_item.out_comp2 <= 16384 &&
       out_item.out_comp3 >= -16384 && out_item.out_comp3 <= 16384))
    else $error("component outside unit range");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind quaternion_normalizer qn_checker u_qn_checker (.*);
